// ----- sv/smhs_pkg.sv -----
// smhs_pkg: shared types and constants of the stepper move and home sequencer
// no dependencies; imported by every module of the block
`default_nettype none

package smhs_pkg;

    localparam int DIST_W     = 32;
    localparam int LEN_W      = 32;
    localparam int CNT_W      = 33;
    localparam int TICK_W     = 16;
    localparam int CODE_W     = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 8;
    localparam int DIV_CNT_W  = $clog2(LEN_W);

    localparam int QUEUE_DEPTH_DEF = 2;

    // reset values of the configuration registers
    localparam logic [LEN_W-1:0]  COARSE_RST   = 32'd65536;
    localparam logic [LEN_W-1:0]  FINE_RST     = 32'd16384;
    localparam logic [TICK_W-1:0] INTERVAL_RST = 16'd1000;
    localparam logic              ROTARY_RST   = 1'b0;
    localparam logic [TICK_W-1:0] RIGHT_RST    = 16'd0;
    localparam logic [CODE_W-1:0] HALF_RST     = 3'd1;
    localparam logic [CODE_W-1:0] EIGHTH_RST   = 3'd3;
    localparam logic [CODE_W-1:0] INITIAL_RST  = 3'd2;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_MOVE = 2'd1,
        CMD_HOME = 2'd2,
        CMD_RSVD = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        K_NOP  = 2'd0,
        K_TICK = 2'd1,
        K_MOVE = 2'd2,
        K_HOME = 2'd3
    } kind_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_COARSE   = 3'd0,
        CFG_FINE     = 3'd1,
        CFG_INTERVAL = 3'd2,
        CFG_ROTARY   = 3'd3,
        CFG_RIGHT    = 3'd4,
        CFG_HALF     = 3'd5,
        CFG_EIGHTH   = 3'd6,
        CFG_INITIAL  = 3'd7
    } cfg_idx_t;

    typedef enum logic [5:0] {
        PH_IDLE      = 6'b000001,
        PH_COARSE    = 6'b000010,
        PH_FINE      = 6'b000100,
        PH_HOME_SEEK = 6'b001000,
        PH_HOME_LOW  = 6'b010000,
        PH_ROT       = 6'b100000
    } phase_t;

    typedef struct packed {
        kind_t             kind;
        logic [DIST_W-1:0] mag;
        logic              fwd;
        logic              limit;
    } item_t;

    typedef struct packed {
        logic [LEN_W-1:0]  coarse;
        logic [LEN_W-1:0]  fine;
        logic [TICK_W-1:0] interval;
        logic              rotary;
        logic [TICK_W-1:0] right;
        logic [CODE_W-1:0] half;
        logic [CODE_W-1:0] eighth;
    } cfg_t;

endpackage

`default_nettype wire

// ----- sv/smhs_front.sv -----
// smhs_front: accepts input requests, decodes the command and folds the distance
// into magnitude and direction; depends on smhs_pkg
`default_nettype none

module smhs_front
    import smhs_pkg::*;
(
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [IN_DATA_W-1:0] s_axis_tdata,   // distance, limit_switch
    input  wire logic [IN_USER_W-1:0] s_axis_tuser,   // cmd
    input  wire logic                 q_full,
    output logic                      q_push,
    output item_t                     q_item
);

    logic [DIST_W-1:0] raw_dist;
    logic              neg;

    assign raw_dist      = s_axis_tdata[DIST_W-1:0];
    assign neg           = raw_dist[DIST_W-1];
    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    always_comb
    begin
        unique case (cmd_t'(s_axis_tuser))
            CMD_TICK: q_item.kind = K_TICK;
            CMD_MOVE: q_item.kind = K_MOVE;
            CMD_HOME: q_item.kind = K_HOME;
            default:  q_item.kind = K_NOP;
        endcase
        // most negative distance folds to 2^31, still exact as unsigned
        q_item.mag   = neg ? (DIST_W'(0) - raw_dist) : raw_dist;
        q_item.fwd   = !neg && (raw_dist != '0);
        q_item.limit = s_axis_tdata[DIST_W];
    end

endmodule

`default_nettype wire

// ----- sv/smhs_queue.sv -----
// smhs_queue: short request queue between front and back
// depends on smhs_pkg for the item type
`default_nettype none

module smhs_queue
    import smhs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  item_t      push_item,
    input  wire logic  pop,
    output item_t      pop_item,
    output logic       full,
    output logic       empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    item_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0]  count_reg, count_next;
    logic               do_push, do_pop;

    assign full     = (count_reg == CNT_QW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_QW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_QW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- sv/smhs_div.sv -----
// smhs_div: restoring unsigned divider, one quotient bit per cycle
// depends on smhs_pkg for widths
`default_nettype none

module smhs_div
    import smhs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [LEN_W-1:0] dividend,
    input  wire logic [LEN_W-1:0] divisor,
    output logic                  done,
    output logic [LEN_W-1:0]      quotient,
    output logic [LEN_W-1:0]      remainder
);

    logic                 active_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [LEN_W-1:0]     rem_reg, rem_next;
    logic [LEN_W-1:0]     quo_reg, quo_next;
    logic [LEN_W-1:0]     dvs_reg;
    logic [LEN_W:0]       shifted;
    logic                 ge;
    logic                 last;

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign last      = (cnt_reg == DIV_CNT_W'(LEN_W - 1));

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[LEN_W-1]};
        ge       = (shifted >= {1'b0, dvs_reg});
        rem_next = ge ? LEN_W'(shifted - {1'b0, dvs_reg}) : shifted[LEN_W-1:0];
        quo_next = {quo_reg[LEN_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= active_reg && last;
            if (start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= '0;
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (last)
                begin
                    active_reg <= 1'b0;
                end
            end
        end
    end

    // dividend enters the quotient register and shifts out into the remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (active_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/smhs_back.sv -----
// smhs_back: motion sequencer; pops requests, runs the move division, steps the
// motion state and holds the result register; depends on smhs_pkg, smhs_div
`default_nettype none

module smhs_back
    import smhs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  cfg_t                       cfg,
    input  wire logic                  q_empty,
    input  item_t                      q_item,
    output logic                       q_pop,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    typedef enum logic [3:0] {
        BS_POP  = 4'b0001,
        BS_DIVC = 4'b0010,
        BS_DIVF = 4'b0100,
        BS_EXEC = 4'b1000
    } bstate_t;

    bstate_t           bs_reg, bs_next;
    item_t             cur_reg;
    logic [LEN_W-1:0]  nc_reg;
    logic [LEN_W-1:0]  nf_reg;

    phase_t            ph_reg, ph_next, p_ph;
    logic [TICK_W-1:0] tick_reg, tick_next, p_tick;
    logic [CNT_W-1:0]  coarse_reg, coarse_next, p_coarse;
    logic [CNT_W-1:0]  fine_reg, fine_next, p_fine;
    logic              step_reg, step_next, p_step;
    logic              dir_reg, dir_next, p_dir;
    logic [CODE_W-1:0] us_reg, us_next, p_us;
    logic              run;
    logic              done;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  commit;

    logic              start_c, start_f;
    logic              div_start, div_done;
    logic [LEN_W-1:0]  div_dividend, div_divisor, div_quo, div_rem;
    logic [LEN_W-1:0]  cl_eff, fl_eff;
    logic              round_up;

    assign cl_eff = (cfg.coarse == '0) ? LEN_W'(1) : cfg.coarse;
    assign fl_eff = (cfg.fine == '0) ? LEN_W'(1) : cfg.fine;

    assign q_pop   = (bs_reg == BS_POP) && !q_empty;
    assign start_c = q_pop && (q_item.kind == K_MOVE) && (ph_reg == PH_IDLE);
    assign start_f = (bs_reg == BS_DIVC) && div_done;
    assign commit  = (bs_reg == BS_EXEC) && (!out_valid_reg || m_axis_tready);

    assign div_start    = start_c || start_f;
    assign div_dividend = start_c ? q_item.mag : div_rem;
    assign div_divisor  = start_c ? cl_eff : fl_eff;
    // fine count rounds half up: one more when twice the remainder reaches the length
    assign round_up     = ({div_rem, 1'b0} >= {1'b0, fl_eff});

    smhs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        bs_next = bs_reg;
        unique case (bs_reg)
            BS_POP:
            begin
                if (q_pop)
                begin
                    bs_next = start_c ? BS_DIVC : BS_EXEC;
                end
            end
            BS_DIVC:
            begin
                if (div_done)
                begin
                    bs_next = BS_DIVF;
                end
            end
            BS_DIVF:
            begin
                if (div_done)
                begin
                    bs_next = BS_EXEC;
                end
            end
            BS_EXEC:
            begin
                if (commit)
                begin
                    bs_next = BS_POP;
                end
            end
            default: bs_next = BS_POP;
        endcase
    end

    // command preamble: what the request sets before the due actions run
    always_comb
    begin
        p_ph     = ph_reg;
        p_tick   = tick_reg;
        p_coarse = coarse_reg;
        p_fine   = fine_reg;
        p_step   = step_reg;
        p_dir    = dir_reg;
        p_us     = us_reg;
        run      = 1'b0;
        unique case (cur_reg.kind)
            K_TICK:
            begin
                if (ph_reg != PH_IDLE)
                begin
                    p_tick = (tick_reg != '0) ? tick_reg - TICK_W'(1) : '0;
                    run    = (p_tick == '0);
                end
            end
            K_MOVE:
            begin
                if (ph_reg == PH_IDLE)
                begin
                    p_dir    = cur_reg.fwd;
                    p_coarse = {nc_reg, 1'b0};
                    p_fine   = {nf_reg, 1'b0};
                    p_us     = cfg.half;
                    p_tick   = '0;
                    p_ph     = PH_COARSE;
                    run      = 1'b1;
                end
            end
            K_HOME:
            begin
                if (ph_reg == PH_IDLE)
                begin
                    p_dir  = 1'b0;
                    p_tick = '0;
                    p_ph   = PH_HOME_SEEK;
                    run    = 1'b1;
                end
            end
            default: run = 1'b0;
        endcase
    end

    // due actions; at most one phase hand-over happens before a toggle or finish
    always_comb
    begin
        ph_next     = p_ph;
        tick_next   = p_tick;
        coarse_next = p_coarse;
        fine_next   = p_fine;
        step_next   = p_step;
        dir_next    = p_dir;
        us_next     = p_us;
        done        = 1'b0;
        if (run)
        begin
            unique case (p_ph) inside
                PH_COARSE, PH_ROT:
                begin
                    if (p_coarse != '0)
                    begin
                        step_next   = ~p_step;
                        coarse_next = p_coarse - CNT_W'(1);
                        tick_next   = cfg.interval;
                    end
                    else if (p_ph == PH_ROT)
                    begin
                        ph_next = PH_IDLE;
                        done    = 1'b1;
                    end
                    else
                    begin
                        us_next = cfg.eighth;
                        if (p_fine != '0)
                        begin
                            ph_next   = PH_FINE;
                            step_next = ~p_step;
                            fine_next = p_fine - CNT_W'(1);
                            tick_next = cfg.interval;
                        end
                        else
                        begin
                            ph_next = PH_IDLE;
                            done    = 1'b1;
                        end
                    end
                end
                PH_FINE:
                begin
                    if (p_fine != '0)
                    begin
                        step_next = ~p_step;
                        fine_next = p_fine - CNT_W'(1);
                        tick_next = cfg.interval;
                    end
                    else
                    begin
                        ph_next = PH_IDLE;
                        done    = 1'b1;
                    end
                end
                PH_HOME_SEEK:
                begin
                    if (!cur_reg.limit)
                    begin
                        step_next = 1'b1;
                        tick_next = cfg.interval;
                        ph_next   = PH_HOME_LOW;
                    end
                    else if (!cfg.rotary)
                    begin
                        ph_next = PH_IDLE;
                        done    = 1'b1;
                    end
                    else
                    begin
                        us_next  = cfg.eighth;
                        dir_next = 1'b1;
                        if (cfg.right != '0)
                        begin
                            ph_next     = PH_ROT;
                            step_next   = ~p_step;
                            coarse_next = CNT_W'(cfg.right) - CNT_W'(1);
                            tick_next   = cfg.interval;
                        end
                        else
                        begin
                            coarse_next = '0;
                            ph_next     = PH_IDLE;
                            done        = 1'b1;
                        end
                    end
                end
                PH_HOME_LOW:
                begin
                    step_next = 1'b0;
                    tick_next = cfg.interval;
                    ph_next   = PH_HOME_SEEK;
                end
                default: ph_next = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bs_reg        <= BS_POP;
            ph_reg        <= PH_IDLE;
            tick_reg      <= '0;
            coarse_reg    <= '0;
            fine_reg      <= '0;
            step_reg      <= 1'b0;
            dir_reg       <= 1'b0;
            us_reg        <= INITIAL_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bs_reg <= bs_next;
            if (commit)
            begin
                ph_reg        <= ph_next;
                tick_reg      <= tick_next;
                coarse_reg    <= coarse_next;
                fine_reg      <= fine_next;
                step_reg      <= step_next;
                dir_reg       <= dir_next;
                us_reg        <= us_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_item;
        end
        if ((bs_reg == BS_DIVC) && div_done)
        begin
            nc_reg <= div_quo;
        end
        if ((bs_reg == BS_DIVF) && div_done)
        begin
            nf_reg <= div_quo + LEN_W'(round_up);
        end
        if (commit)
        begin
            out_data_reg <= {1'b0, done, (ph_next != PH_IDLE), us_next, dir_next, step_next};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ----- sv/stepper_move_and_home_sequencer_unit.sv -----
// stepper_move_and_home_sequencer_unit: tick, move and homing requests in,
// step, direction and microstep status out, one result per request
// path: tick, homing and ignored requests go from queue head to the request
// register and then to the result register; a move start first runs the divider
// for coarse and fine counts; the next request is popped once the result commits
// reset: asynchronous, clears queue and motion state, microstep pattern 2
`default_nettype none

module stepper_move_and_home_sequencer_unit
    import smhs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // distance, limit_switch, zero pad
    input  wire logic [IN_USER_W-1:0]  s_axis_tuser,   // cmd
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata    // step_level, direction,
                                                       // microstep_code, busy_res,
                                                       // done_res, zero pad
);

    cfg_t  cfg_reg;
    item_t push_item, pop_item;
    logic  q_push, q_pop, q_full, q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coarse   <= COARSE_RST;
            cfg_reg.fine     <= FINE_RST;
            cfg_reg.interval <= INTERVAL_RST;
            cfg_reg.rotary   <= ROTARY_RST;
            cfg_reg.right    <= RIGHT_RST;
            cfg_reg.half     <= HALF_RST;
            cfg_reg.eighth   <= EIGHTH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_COARSE:   cfg_reg.coarse   <= cfg_wdata[LEN_W-1:0];
                CFG_FINE:     cfg_reg.fine     <= cfg_wdata[LEN_W-1:0];
                CFG_INTERVAL: cfg_reg.interval <= cfg_wdata[TICK_W-1:0];
                CFG_ROTARY:   cfg_reg.rotary   <= cfg_wdata[0];
                CFG_RIGHT:    cfg_reg.right    <= cfg_wdata[TICK_W-1:0];
                CFG_HALF:     cfg_reg.half     <= cfg_wdata[CODE_W-1:0];
                CFG_EIGHTH:   cfg_reg.eighth   <= cfg_wdata[CODE_W-1:0];
                // initial pattern only matters at reset, later writes have no effect
                default:      cfg_reg.eighth   <= cfg_reg.eighth;
            endcase
        end
    end

    smhs_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    smhs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    smhs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_empty       (q_empty),
        .q_item        (pop_item),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

`ifndef NO_ASSERTIONS
    // a finishing result never reports motion still running
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[6] && m_axis_tdata[5]))
        else $error("done and busy both set in a result");

    // front must stall while the queue is full
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !s_axis_tready && !q_push)
        else $error("request taken while queue full");

    // the back pops only a held entry
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ----- verif/smhs_status_checker.sv -----
// smhs_status_checker: watches the config port and both stream channels of the
// stepper sequencer, predicts each status result and compares it field by field
// depends on smhs_pkg for the command, phase, config index and config types
`default_nettype none

module smhs_status_checker
    import smhs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic [IN_USER_W-1:0]  s_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata,
    output int unsigned                n_waiting,
    output int unsigned                n_fail
);
    timeunit 1ns;
    timeprecision 1ps;

    // same order as the result bits, lowest field last
    typedef struct packed {
        logic              done;
        logic              busy;
        logic [CODE_W-1:0] ustep;
        logic              dir;
        logic              step;
    } status_t;

    cfg_t              cfg;
    logic [CODE_W-1:0] init_code;

    phase_t            mphase;
    logic [TICK_W-1:0] tick_cnt;
    logic [CNT_W-1:0]  coarse_left;
    logic [CNT_W-1:0]  fine_left;
    logic              step_lvl;
    logic              dir_lvl;
    logic [CODE_W-1:0] ustep;
    logic [63:0]       rem_work;

    status_t           pending_status[$];
    int unsigned       fails = 0;

    function automatic void take_toggle(inout logic [CNT_W-1:0] left);
        step_lvl = ~step_lvl;
        left     = left - 1'b1;
        tick_cnt = cfg.interval;
    endfunction

    // carries out every action that is due now, returns 1 when motion ends
    function automatic logic run_due(input logic lim);
        logic fin;
        logic more;
        fin  = 1'b0;
        more = 1'b1;
        while (more)
        begin
            more = 1'b0;
            case (mphase)
                PH_COARSE:
                    if (coarse_left != 0)
                        take_toggle(coarse_left);
                    else
                    begin
                        ustep  = cfg.eighth;
                        mphase = PH_FINE;
                        more   = 1'b1;
                    end
                PH_FINE:
                    if (fine_left != 0)
                        take_toggle(fine_left);
                    else
                    begin
                        mphase = PH_IDLE;
                        fin    = 1'b1;
                    end
                PH_HOME_SEEK:
                    if (!lim)
                    begin
                        step_lvl = 1'b1;
                        tick_cnt = cfg.interval;
                        mphase   = PH_HOME_LOW;
                    end
                    else if (!cfg.rotary)
                    begin
                        mphase = PH_IDLE;
                        fin    = 1'b1;
                    end
                    else
                    begin
                        // right-angle turn toward the board
                        ustep       = cfg.eighth;
                        dir_lvl     = 1'b1;
                        coarse_left = CNT_W'(cfg.right);
                        mphase      = PH_ROT;
                        more        = 1'b1;
                    end
                PH_HOME_LOW:
                begin
                    step_lvl = 1'b0;
                    tick_cnt = cfg.interval;
                    mphase   = PH_HOME_SEEK;
                end
                PH_ROT:
                    if (coarse_left != 0)
                        take_toggle(coarse_left);
                    else
                    begin
                        mphase = PH_IDLE;
                        fin    = 1'b1;
                    end
                default:
                    mphase = PH_IDLE;
            endcase
        end
        return fin;
    endfunction

    function automatic status_t next_status(input cmd_t c, input logic [DIST_W-1:0] d,
                                            input logic lim);
        logic              fin;
        logic              neg;
        logic [DIST_W-1:0] mag32;
        logic [63:0]       mag;
        logic [63:0]       cl;
        logic [63:0]       fl;
        logic [63:0]       nc;
        logic [63:0]       nf;
        status_t           s;
        fin = 1'b0;
        case (c)
            CMD_TICK:
                if (mphase != PH_IDLE)
                begin
                    if (tick_cnt != 0)
                        tick_cnt = tick_cnt - 1'b1;
                    if (tick_cnt == 0)
                        fin = run_due(lim);
                end
            CMD_MOVE:
                if (mphase == PH_IDLE)
                begin
                    neg   = d[DIST_W-1];
                    mag32 = neg ? (~d + 32'd1) : d;
                    mag   = {32'b0, mag32};
                    // zero lengths count as one
                    cl    = (cfg.coarse == 0) ? 64'd1 : {32'b0, cfg.coarse};
                    fl    = (cfg.fine == 0) ? 64'd1 : {32'b0, cfg.fine};
                    dir_lvl     = !neg && (d != 0);
                    nc          = mag / cl;
                    rem_work    = mag - nc * cl;
                    // fine count rounded half up
                    nf          = (2 * rem_work + fl) / (2 * fl);
                    coarse_left = CNT_W'(2 * nc);
                    fine_left   = CNT_W'(2 * nf);
                    ustep       = cfg.half;
                    tick_cnt    = '0;
                    mphase      = PH_COARSE;
                    fin         = run_due(lim);
                end
            CMD_HOME:
                if (mphase == PH_IDLE)
                begin
                    dir_lvl  = 1'b0;
                    tick_cnt = '0;
                    mphase   = PH_HOME_SEEK;
                    fin      = run_due(lim);
                end
            default:
                ;
        endcase
        s.step  = step_lvl;
        s.dir   = dir_lvl;
        s.ustep = ustep;
        s.busy  = (mphase != PH_IDLE);
        s.done  = fin;
        return s;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned got_val);
        if (exp_val != got_val)
        begin
            fails++;
            $display("%0t: status %s mismatch, expected %0d, got %0d",
                     $realtime, name, exp_val, got_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        status_t exp_s;
        status_t got_s;
        if (!rst_n)
        begin
            cfg         = '{coarse: COARSE_RST, fine: FINE_RST, interval: INTERVAL_RST,
                            rotary: ROTARY_RST, right: RIGHT_RST, half: HALF_RST,
                            eighth: EIGHTH_RST};
            init_code   = INITIAL_RST;
            mphase      = PH_IDLE;
            tick_cnt    = '0;
            coarse_left = '0;
            fine_left   = '0;
            step_lvl    = 1'b0;
            dir_lvl     = 1'b0;
            ustep       = INITIAL_RST;
            rem_work    = '0;
            pending_status.delete();
            n_waiting  <= 0;
            n_fail     <= fails;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_addr))
                    CFG_COARSE:   cfg.coarse   = cfg_wdata[LEN_W-1:0];
                    CFG_FINE:     cfg.fine     = cfg_wdata[LEN_W-1:0];
                    CFG_INTERVAL: cfg.interval = cfg_wdata[TICK_W-1:0];
                    CFG_ROTARY:   cfg.rotary   = cfg_wdata[0];
                    CFG_RIGHT:    cfg.right    = cfg_wdata[TICK_W-1:0];
                    CFG_HALF:     cfg.half     = cfg_wdata[CODE_W-1:0];
                    CFG_EIGHTH:   cfg.eighth   = cfg_wdata[CODE_W-1:0];
                    CFG_INITIAL:  init_code    = cfg_wdata[CODE_W-1:0];
                    default:      ;
                endcase
            end
            if (s_tvalid && s_tready)
                pending_status.push_back(next_status(cmd_t'(s_tuser), s_tdata[DIST_W-1:0],
                                                     s_tdata[DIST_W]));
            if (m_tvalid && m_tready)
            begin
                got_s = m_tdata[6:0];
                if (pending_status.size() == 0)
                begin
                    fails++;
                    $display("%0t: status result with no request waiting, expected none, got %h",
                             $realtime, got_s);
                end
                else
                begin
                    exp_s = pending_status.pop_front();
                    check_field("step_level", exp_s.step, got_s.step);
                    check_field("direction", exp_s.dir, got_s.dir);
                    check_field("microstep_code", exp_s.ustep, got_s.ustep);
                    check_field("busy", exp_s.busy, got_s.busy);
                    check_field("done", exp_s.done, got_s.done);
                end
            end
            n_waiting <= pending_status.size();
            n_fail    <= fails;
        end
    end

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// tb: stimulus and verdict for stepper_move_and_home_sequencer_unit
// depends on smhs_pkg, the unit itself and smhs_status_checker
`default_nettype none

module tb;
    import smhs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned END_WAIT       = 120;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int unsigned n_waiting;
    int unsigned n_fail;
    int unsigned tx_idle = 25;
    int unsigned rx_idle = 64;
    bit          rx_hold_req = 1'b0;
    int unsigned items_sent = 0;
    int unsigned quiet_cycles = 0;
    cfg_t        cur;

    stepper_move_and_home_sequencer_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    smhs_status_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_axis_tvalid),
        .s_tready  (s_axis_tready),
        .s_tdata   (s_axis_tdata),
        .s_tuser   (s_axis_tuser),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tdata   (m_axis_tdata),
        .n_waiting (n_waiting),
        .n_fail    (n_fail)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // result side: random back-pressure, or a long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= rx_idle);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no request or result moved for %0d cycles",
                         $realtime, quiet_cycles);
                $display("** stepper_move_and_home_sequencer_unit: FAILED **");
                $finish;
            end
        end
    end

    function automatic int unsigned iv_eff();
        return (cur.interval == 0) ? 1 : cur.interval;
    endfunction

    // distances sized so that a move ends within a few dozen toggles
    function automatic logic [DIST_W-1:0] gen_distance();
        longint unsigned cl;
        longint unsigned fl;
        longint unsigned mag;
        int unsigned     pick;
        cl   = (cur.coarse == 0) ? 1 : cur.coarse;
        fl   = (cur.fine == 0) ? 1 : cur.fine;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        if (cl >= 64'h1000_0000)
        begin
            if (pick == 1)
                return 32'h8000_0000;
            if (pick == 2)
                return 32'h7FFF_FFFF;
            return $urandom();
        end
        mag = $urandom_range(0, 3) * cl;
        if (pick < 4)
            mag += (fl / 2 + fl * $urandom_range(0, 3)) % cl;   // near the rounding point
        else
            mag += $urandom() % cl;
        return $urandom_range(0, 1) ? 32'(mag) : 32'(0 - mag);
    endfunction

    task automatic send_req(input cmd_t c, input logic [DIST_W-1:0] d, input logic lim);
        while ($urandom_range(0, 99) < tx_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c;
        s_axis_tdata  <= {{(IN_DATA_W - DIST_W - 1){1'b0}}, lim, d};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic feed_ticks(input int unsigned n, input int unsigned lim_from,
                              input bit noisy);
        cmd_t noise_cmd;
        for (int unsigned i = 0; i < n; i++)
        begin
            if (noisy && $urandom_range(0, 11) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       noise_cmd = CMD_MOVE;
                    1:       noise_cmd = CMD_HOME;
                    default: noise_cmd = CMD_RSVD;
                endcase
                send_req(noise_cmd, (noise_cmd == CMD_MOVE) ? gen_distance() : $urandom(),
                         $urandom_range(0, 1));
            end
            send_req(CMD_TICK, $urandom(), (i >= lim_from) || ($urandom_range(0, 15) == 0));
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (n_waiting != 0);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic load_setting(input cfg_t c, input logic [CODE_W-1:0] init_code);
        wait_drained();
        write_reg(CFG_COARSE, c.coarse);
        write_reg(CFG_FINE, c.fine);
        write_reg(CFG_INTERVAL, CFG_DATA_W'(c.interval));
        write_reg(CFG_ROTARY, CFG_DATA_W'(c.rotary));
        write_reg(CFG_RIGHT, CFG_DATA_W'(c.right));
        write_reg(CFG_HALF, CFG_DATA_W'(c.half));
        write_reg(CFG_EIGHTH, CFG_DATA_W'(c.eighth));
        write_reg(CFG_INITIAL, CFG_DATA_W'(init_code));
        cfg_we <= 1'b0;
        cur = c;
    endtask

    task automatic run_move();
        logic [DIST_W-1:0] d;
        logic [DIST_W-1:0] mag;
        longint unsigned   cl;
        longint unsigned   fl;
        longint unsigned   q;
        d   = gen_distance();
        mag = d[DIST_W-1] ? (~d + 32'd1) : d;
        cl  = (cur.coarse == 0) ? 1 : cur.coarse;
        fl  = (cur.fine == 0) ? 1 : cur.fine;
        q   = mag / cl;
        send_req(CMD_MOVE, d, $urandom_range(0, 1));
        feed_ticks((2 * q + 2 * ((mag - q * cl) / fl) + 3) * iv_eff(),
                   $urandom_range(0, 20), 1'b1);
    endtask

    // homing with a random number of home steps before the switch closes
    task automatic run_home();
        int unsigned h;
        int unsigned iv;
        h  = $urandom_range(0, 3);
        iv = iv_eff();
        send_req(CMD_HOME, $urandom(), h == 0);
        feed_ticks(2 * iv * h + (cur.rotary ? cur.right * iv : 0) + 2 * iv + 2,
                   (h == 0) ? 0 : 2 * iv * h - 1, 1'b1);
    endtask

    task automatic random_phase(input int unsigned n, input bit hold_mid, input bit pause_mid);
        int unsigned start;
        int unsigned r;
        bit          mid_done;
        cmd_t        c;
        start    = items_sent;
        mid_done = 1'b0;
        while (items_sent - start < n)
        begin
            if (!mid_done && items_sent - start >= n / 2)
            begin
                mid_done = 1'b1;
                if (hold_mid)
                    rx_hold_req = 1'b1;
                if (pause_mid)
                    wait_drained();
            end
            r = $urandom_range(0, 99);
            if (r < 45)
                run_move();
            else if (r < 80)
                run_home();
            else
            begin
                c = cmd_t'($urandom_range(0, 3));
                send_req(c, (c == CMD_MOVE) ? gen_distance() : $urandom(), $urandom_range(0, 1));
            end
        end
        // enough ticks with the switch closed to end whatever still runs
        feed_ticks((48 + (cur.rotary ? cur.right : 0)) * iv_eff(), 0, 1'b0);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        load_setting('{coarse: 32'd65536, fine: 32'd16384, interval: 16'd2, rotary: 1'b1,
                       right: 16'd3, half: 3'd1, eighth: 3'd3}, 3'd2);
        send_req(CMD_RSVD, 32'hFFFF_FFFF, 1'b1);
        send_req(CMD_TICK, 32'h0000_0000, 1'b0);
        send_req(CMD_MOVE, 32'h0000_0000, 1'b0);
        // one coarse step plus exactly half a fine step, starts ignored while busy
        send_req(CMD_MOVE, 32'h0001_2000, 1'b0);
        send_req(CMD_MOVE, 32'h7FFF_FFFF, 1'b1);
        send_req(CMD_TICK, 32'h0000_0000, 1'b0);
        send_req(CMD_HOME, 32'h8000_0000, 1'b1);
        feed_ticks(8, 0, 1'b0);
        // just under half a fine step backward, no toggles
        send_req(CMD_MOVE, 32'hFFFF_E001, 1'b0);
        // switch already closed, straight into the right-angle turn
        send_req(CMD_HOME, 32'h0000_0000, 1'b1);
        feed_ticks(7, 0, 1'b0);

        load_setting('{coarse: 32'd4096, fine: 32'd1024, interval: 16'd1, rotary: 1'b0,
                       right: 16'd0, half: 3'd5, eighth: 3'd6}, 3'd7);
        random_phase(60, 1'b1, 1'b0);

        tx_idle = 64;
        rx_idle = 25;
        load_setting('{coarse: 32'd0, fine: 32'd0, interval: 16'd0, rotary: 1'b1,
                       right: 16'd2, half: 3'd0, eighth: 3'd7}, 3'd0);
        random_phase(60, 1'b0, 1'b1);
        load_setting('{coarse: 32'hFFFF_FFFF, fine: 32'h2000_0000, interval: 16'd3,
                       rotary: 1'b0, right: 16'd40, half: 3'd7, eighth: 3'd0}, 3'd5);
        random_phase(60, 1'b0, 1'b0);

        tx_idle = 0;
        rx_idle = 0;
        load_setting('{coarse: 32'h1000_0000, fine: 32'hFFFF_FFFF, interval: 16'd2,
                       rotary: 1'b1, right: 16'd5, half: 3'd2, eighth: 3'd4}, 3'd1);
        random_phase(60, 1'b0, 1'b0);

        // widest right-angle count, then the longest interval while the turn still runs
        load_setting('{coarse: 32'd65536, fine: 32'd16384, interval: 16'd1, rotary: 1'b1,
                       right: 16'hFFFF, half: 3'd1, eighth: 3'd3}, 3'd2);
        send_req(CMD_HOME, $urandom(), 1'b1);
        feed_ticks(8, 0, 1'b0);
        load_setting('{coarse: 32'd65536, fine: 32'd16384, interval: 16'hFFFF, rotary: 1'b1,
                       right: 16'hFFFF, half: 3'd6, eighth: 3'd1}, 3'd4);
        send_req(CMD_MOVE, 32'h0001_0000, 1'b0);
        feed_ticks(6, 0, 1'b0);

        wait_drained();
        repeat (END_WAIT) @(posedge clk);
        if (n_fail == 0 && n_waiting == 0)
            $display("** stepper_move_and_home_sequencer_unit: PASSED **");
        else
            $display("** stepper_move_and_home_sequencer_unit: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
